// ----- hdl/video_frame_sync_queue_assert.svh -----
// assertion macros shared by the frame sync queue modules
`ifndef VIDEO_FRAME_SYNC_QUEUE_ASSERT_SVH
`define VIDEO_FRAME_SYNC_QUEUE_ASSERT_SVH

// checked property, switched off while reset is held
`define VFSQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked property, live through reset as well
`define VFSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/vfsq_pkg.sv -----
// shared types, codes and constants of the frame sync queue
package vfsq_pkg;

  // field widths
  localparam int TIME_W  = 47;
  localparam int TAG_W   = 16;
  localparam int DRIFT_W = 48;
  localparam int DIFF_W  = 50;
  localparam int THR_W   = 20;
  localparam int FDUP_W  = 24;
  localparam int NOS_W   = 27;
  localparam int MQ_W    = 3;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 27;
  localparam int ENT_W   = TAG_W + TIME_W;

  localparam int DEPTH_DEF = 4;
  localparam int MAX_RES   = 4;

  // register reset values
  localparam logic [MQ_W-1:0]   MAX_QUEUE_RST = 3'd3;
  localparam logic [THR_W-1:0]  SYNC_MIN_RST  = 20'd10000;
  localparam logic [THR_W-1:0]  SYNC_MAX_RST  = 20'd100000;
  localparam logic [FDUP_W-1:0] FRAMEDUP_RST  = 24'd100000;
  localparam logic [NOS_W-1:0]  NOSYNC_RST    = 27'd10000000;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_MAX_QUEUE = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SYNC_MIN  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SYNC_MAX  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_FRAMEDUP  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_NOSYNC    = 3'd4;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_SETCLK  = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_ACCEPTED = 3'd0,
    K_REFUSED  = 3'd1,
    K_DROPPED  = 3'd2,
    K_SHOWN    = 3'd3,
    K_WAIT     = 3'd4,
    K_IDLE     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_READ,
    S_DIFF,
    S_THR,
    S_DECIDE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  capture;
    logic  act_cmd;
    logic  read_head;
    logic  calc_diff;
    logic  calc_thr;
    logic  act_frame;
    logic  emit;
    kind_t kind;
    logic  last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic full;
    logic count_one;
    logic frm_drop;
    logic frm_wait;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/vfsq_ctrl.sv -----
// sequencer for command handling and head frame evaluation
`include "video_frame_sync_queue_assert.svh"

module vfsq_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  vfsq_pkg::stat_t st,
  output vfsq_pkg::ctl_t  ctl
);
  import vfsq_pkg::*;

  localparam int RC_W = $clog2(MAX_RES);

  state_t            state_r, state_nxt;
  logic [RC_W-1:0]   res_cnt_r, res_cnt_nxt;

  // state and result counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      res_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    res_cnt_nxt = res_cnt_r;
    ctl         = '0;
    ctl.kind    = K_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          res_cnt_nxt = '0;
          state_nxt   = S_CMD;
        end
      end
      S_CMD: begin
        if (st.cmd == CMD_TICK && !st.empty) begin
          state_nxt = S_READ;
        end else if (st.out_free) begin
          ctl.emit    = 1'b1;
          ctl.act_cmd = 1'b1;
          ctl.last    = 1'b1;
          if (st.cmd == CMD_PUSH) begin
            ctl.kind = st.full ? K_REFUSED : K_ACCEPTED;
          end
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        ctl.read_head = 1'b1;
        state_nxt     = S_DIFF;
      end
      S_DIFF: begin
        ctl.calc_diff = 1'b1;
        state_nxt     = S_THR;
      end
      S_THR: begin
        ctl.calc_thr = 1'b1;
        state_nxt    = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.out_free) begin
          ctl.emit      = 1'b1;
          ctl.act_frame = 1'b1;
          if (st.frm_drop) begin
            ctl.kind = K_DROPPED;
            ctl.last = st.count_one || (res_cnt_r == RC_W'(MAX_RES - 1));
          end else begin
            ctl.kind = st.frm_wait ? K_WAIT : K_SHOWN;
            ctl.last = 1'b1;
          end
          res_cnt_nxt = res_cnt_r + 1'b1;
          state_nxt   = ctl.last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // a final result always returns the sequencer to idle
  `VFSQ_ASSERT(a_last_to_idle, clk, rst_n, (ctl.emit && ctl.last) |=> (state_r == S_IDLE), "last result did not end the input")
  // requests are taken only in idle
  `VFSQ_ASSERT_ALWAYS(a_capture_idle, clk, ctl.capture |-> (state_r == S_IDLE), "input taken while busy")

endmodule

// ----- hdl/vfsq_dp.sv -----
// frame store, timing arithmetic, config registers and result register
`include "video_frame_sync_queue_assert.svh"

module vfsq_dp #(
  parameter int DEPTH = vfsq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vfsq_pkg::ctl_t                      ctl,
  output vfsq_pkg::stat_t                     st,
  input  logic [1:0]                          in_cmd,
  input  logic [vfsq_pkg::TIME_W-1:0]         in_pts_us,
  input  logic [vfsq_pkg::TAG_W-1:0]          in_frame_tag,
  input  logic [vfsq_pkg::TIME_W-1:0]         in_now_us,
  input  logic [vfsq_pkg::TIME_W-1:0]         in_clock_us,
  input  logic                                cfg_valid,
  input  logic [vfsq_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [vfsq_pkg::CDAT_W-1:0]         cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_kind,
  output logic [vfsq_pkg::TAG_W-1:0]          out_tag_out,
  output logic [vfsq_pkg::TIME_W-1:0]         out_wait_us,
  output logic signed [vfsq_pkg::DRIFT_W-1:0] out_diff_us,
  output logic                                out_last
);
  import vfsq_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > MQ_W) ? CW : MQ_W;

  // config registers
  logic [MQ_W-1:0]   max_queue_r;
  logic [THR_W-1:0]  sync_min_r;
  logic [THR_W-1:0]  sync_max_r;
  logic [FDUP_W-1:0] framedup_r;
  logic [NOS_W-1:0]  nosync_r;

  // captured request
  cmd_t              cmd_r;
  logic [TIME_W-1:0] pts_in_r;
  logic [TAG_W-1:0]  tag_in_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] clk_in_r;

  // queue state
  logic [AW-1:0]            head_r, head_nxt;
  logic [CW-1:0]            frame_count_r, frame_count_nxt;
  logic signed [DRIFT_W-1:0] drift_r, drift_nxt;
  logic [TIME_W-1:0]        prev_pts_r, prev_pts_nxt;

  // frame store
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_r;

  // evaluation pipeline registers
  logic signed [DIFF_W-1:0]  diff_r;
  logic signed [DRIFT_W-1:0] delay_r;
  logic [THR_W-1:0]          thr_r;
  logic                      sync_r;
  logic [DRIFT_W-1:0]        sat_r;

  // result register
  logic               out_valid_r;
  logic [2:0]         out_kind_r;
  logic [TAG_W-1:0]   out_tag_r;
  logic [TIME_W-1:0]  out_wait_r;
  logic [DRIFT_W-1:0] out_diff_r;
  logic               out_last_r;

  logic                     full;
  logic                     push_ok;
  logic [CMPW-1:0]          cap;
  logic [AW:0]              slot_sum;
  logic [AW-1:0]            slot;
  logic [AW-1:0]            head_inc;
  logic [TIME_W-1:0]        frm_pts;
  logic [TAG_W-1:0]         frm_tag;
  logic signed [DIFF_W-1:0] diff_calc;
  logic signed [DRIFT_W-1:0] delay_calc;
  logic                     gt_max;
  logic [THR_W-1:0]         thr1;
  logic [THR_W-1:0]         thr_calc;
  logic                     in_range;
  logic                     dly_ok;
  logic [DRIFT_W-1:0]       sat_calc;
  logic signed [DIFF_W-1:0] sum_p;
  logic signed [DIFF_W-1:0] sum_m;
  logic                     frm_drop;
  logic                     frm_wait;
  logic [TIME_W-1:0]        wait_val;
  logic                     out_free;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_queue_r <= MAX_QUEUE_RST;
      sync_min_r  <= SYNC_MIN_RST;
      sync_max_r  <= SYNC_MAX_RST;
      framedup_r  <= FRAMEDUP_RST;
      nosync_r    <= NOSYNC_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_QUEUE: max_queue_r <= cfg_data[MQ_W-1:0];
        CFG_SYNC_MIN:  sync_min_r  <= cfg_data[THR_W-1:0];
        CFG_SYNC_MAX:  sync_max_r  <= cfg_data[THR_W-1:0];
        CFG_FRAMEDUP:  framedup_r  <= cfg_data[FDUP_W-1:0];
        CFG_NOSYNC:    nosync_r    <= cfg_data[NOS_W-1:0];
        default: ;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r    <= cmd_t'(in_cmd);
      pts_in_r <= in_pts_us;
      tag_in_r <= in_frame_tag;
      now_r    <= in_now_us;
      clk_in_r <= in_clock_us;
    end
  end

  // occupancy against effective capacity
  assign cap      = (CMPW'(max_queue_r) < CMPW'(DEPTH)) ? CMPW'(max_queue_r) : CMPW'(DEPTH);
  assign full     = (CMPW'(frame_count_r) >= cap);
  assign push_ok  = ctl.act_cmd && (cmd_r == CMD_PUSH) && !full;

  // tail slot and head advance, wrapping at the depth
  assign slot_sum = (AW+1)'(head_r) + (AW+1)'(frame_count_r);
  assign slot     = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                 : slot_sum[AW-1:0];
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  // store write and registered head read
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[slot] <= {tag_in_r, pts_in_r};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.read_head) begin
      rd_r <= mem[head_r];
    end
  end

  assign frm_pts = rd_r[TIME_W-1:0];
  assign frm_tag = rd_r[ENT_W-1:TIME_W];

  // frame minus clock difference and spacing to previous frame
  assign diff_calc  = $signed({3'b000, frm_pts}) - $signed({3'b000, now_r})
                    + $signed({{(DIFF_W-DRIFT_W){drift_r[DRIFT_W-1]}}, drift_r});
  assign delay_calc = $signed({1'b0, frm_pts}) - $signed({1'b0, prev_pts_r});

  always_ff @(posedge clk) begin
    if (ctl.calc_diff) begin
      diff_r  <= diff_calc;
      delay_r <= delay_calc;
    end
  end

  // threshold clamp, range checks and saturated difference
  assign gt_max   = delay_r > $signed({{(DRIFT_W-THR_W){1'b0}}, sync_max_r});
  assign thr1     = gt_max ? sync_max_r : delay_r[THR_W-1:0];
  assign thr_calc = (delay_r[DRIFT_W-1] || (thr1 < sync_min_r)) ? sync_min_r : thr1;
  assign in_range = (diff_r < $signed({{(DIFF_W-NOS_W){1'b0}}, nosync_r}))
                 && (diff_r > -$signed({{(DIFF_W-NOS_W){1'b0}}, nosync_r}));
  assign dly_ok   = delay_r < $signed({{(DRIFT_W-FDUP_W){1'b0}}, framedup_r});

  always_comb begin
    if ((diff_r[DIFF_W-1:DRIFT_W-1] == '0) || (diff_r[DIFF_W-1:DRIFT_W-1] == '1)) begin
      sat_calc = diff_r[DRIFT_W-1:0];
    end else if (diff_r[DIFF_W-1]) begin
      sat_calc = {1'b1, {(DRIFT_W-1){1'b0}}};
    end else begin
      sat_calc = {1'b0, {(DRIFT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.calc_thr) begin
      thr_r  <= thr_calc;
      sync_r <= in_range && dly_ok;
      sat_r  <= sat_calc;
    end
  end

  // drop, wait or show decision
  assign sum_p    = diff_r + $signed({{(DIFF_W-THR_W){1'b0}}, thr_r});
  assign sum_m    = diff_r - $signed({{(DIFF_W-THR_W){1'b0}}, thr_r});
  assign frm_drop = sync_r && (sum_p <= 0);
  assign frm_wait = sync_r && !frm_drop && (sum_m > 0);
  assign wait_val = (sum_m[DIFF_W-1:TIME_W] != '0) ? {TIME_W{1'b1}} : sum_m[TIME_W-1:0];

  // queue state update
  always_comb begin
    head_nxt        = head_r;
    frame_count_nxt = frame_count_r;
    drift_nxt       = drift_r;
    prev_pts_nxt    = prev_pts_r;
    if (ctl.act_cmd) begin
      case (cmd_r)
        CMD_PUSH: begin
          if (!full) frame_count_nxt = frame_count_r + 1'b1;
        end
        CMD_SETCLK: begin
          drift_nxt = $signed({1'b0, now_r}) - $signed({1'b0, clk_in_r});
        end
        CMD_RESTART: begin
          head_nxt        = '0;
          frame_count_nxt = '0;
          drift_nxt       = '0;
          prev_pts_nxt    = '0;
        end
        default: ;
      endcase
    end else if (ctl.act_frame && !frm_wait) begin
      head_nxt        = head_inc;
      frame_count_nxt = frame_count_r - 1'b1;
      prev_pts_nxt    = frm_pts;
      if (!sync_r) begin
        drift_nxt = $signed({1'b0, now_r}) - $signed({1'b0, frm_pts});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      frame_count_r <= '0;
      drift_r       <= '0;
      prev_pts_r    <= '0;
    end else begin
      head_r        <= head_nxt;
      frame_count_r <= frame_count_nxt;
      drift_r       <= drift_nxt;
      prev_pts_r    <= prev_pts_nxt;
    end
  end

  // result register, freed when taken downstream
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_kind_r <= ctl.kind;
      out_last_r <= ctl.last;
      case (ctl.kind)
        K_ACCEPTED, K_REFUSED: begin
          out_tag_r  <= tag_in_r;
          out_wait_r <= '0;
          out_diff_r <= '0;
        end
        K_DROPPED, K_SHOWN: begin
          out_tag_r  <= frm_tag;
          out_wait_r <= '0;
          out_diff_r <= sat_r;
        end
        K_WAIT: begin
          out_tag_r  <= frm_tag;
          out_wait_r <= wait_val;
          out_diff_r <= sat_r;
        end
        default: begin
          out_tag_r  <= '0;
          out_wait_r <= '0;
          out_diff_r <= '0;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_tag_out = out_tag_r;
  assign out_wait_us = out_wait_r;
  assign out_diff_us = $signed(out_diff_r);
  assign out_last    = out_last_r;

  // status back to the sequencer
  assign st.cmd       = cmd_r;
  assign st.empty     = (frame_count_r == '0);
  assign st.full      = full;
  assign st.count_one = (frame_count_r == CW'(1));
  assign st.frm_drop  = frm_drop;
  assign st.frm_wait  = frm_wait;
  assign st.out_free  = out_free;

  // occupancy never passes the store depth
  `VFSQ_ASSERT(a_count_bound, clk, rst_n, frame_count_r <= CW'(DEPTH), "frame count beyond depth")
  // a frame is popped only from a non-empty queue
  `VFSQ_ASSERT(a_pop_nonempty, clk, rst_n, (ctl.act_frame && !frm_wait) |-> (frame_count_r != '0), "pop from empty queue")
  // a new result never overwrites one still waiting
  `VFSQ_ASSERT(a_emit_free, clk, rst_n, ctl.emit |-> (!out_valid_r || !out_stall), "result overwritten")

endmodule

// ----- hdl/video_frame_sync_queue.sv -----
// top level of the frame pacing queue: sequencer plus datapath
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | cmd, pts_us, frame_tag, now_us, clock_us
//  out     | output    | out_valid/out_stall| kind, tag_out, wait_us, diff_us, last
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// push, set clock, restart and an empty tick are answered from the command step.
// a tick on a non-empty queue steps each head frame examined through store read,
// difference, threshold clamp and decision, at most 4 frames.
// one request is worked on at a time; in_stall is high from capture to the last result.
// a stalled out channel holds the sequencer in its result step until the slot frees.
// synchronous active-low reset clears the queue, drift and last pts and loads
// the register defaults; cfg_ready is always high.

module video_frame_sync_queue #(
  parameter int DEPTH = vfsq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_cmd,
  input  logic [vfsq_pkg::TIME_W-1:0]         in_pts_us,
  input  logic [vfsq_pkg::TAG_W-1:0]          in_frame_tag,
  input  logic [vfsq_pkg::TIME_W-1:0]         in_now_us,
  input  logic [vfsq_pkg::TIME_W-1:0]         in_clock_us,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_kind,
  output logic [vfsq_pkg::TAG_W-1:0]          out_tag_out,
  output logic [vfsq_pkg::TIME_W-1:0]         out_wait_us,
  output logic signed [vfsq_pkg::DRIFT_W-1:0] out_diff_us,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vfsq_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [vfsq_pkg::CDAT_W-1:0]         cfg_data
);
  import vfsq_pkg::*;

  ctl_t  ctl;
  stat_t st;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // sequencer
  vfsq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  // datapath
  vfsq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .st           (st),
    .in_cmd       (in_cmd),
    .in_pts_us    (in_pts_us),
    .in_frame_tag (in_frame_tag),
    .in_now_us    (in_now_us),
    .in_clock_us  (in_clock_us),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_tag_out  (out_tag_out),
    .out_wait_us  (out_wait_us),
    .out_diff_us  (out_diff_us),
    .out_last     (out_last)
  );

endmodule
